// ===== hdl/tsc_pkg.sv =====
// Shared types, constants and coefficient tables for the Taylor sine/cosine core.
// No dependencies; every other file in hdl/ imports this package.
package tsc_pkg;

	localparam int MAX_TERMS  = 10;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// round(2^40/(2*pi)) split at bit 32
	localparam logic [31:0] TURN_KL = 32'hBE60_DB94;
	localparam logic [6:0]  TURN_KH = 7'h28;
	// round(2*pi*2^30): bit 32 set plus this low word
	localparam logic [31:0] TWO_PI_L = 32'h921F_B544;

	localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [63:0] ONE_Q62      = 64'h4000_0000_0000_0000;
	localparam logic [31:0] ONE_Q30      = 32'h4000_0000;
	localparam logic [3:0]  TERMS_RESET  = 4'd6;

	localparam logic [64:0] TWO_64 = 65'h1_0000_0000_0000_0000;

	typedef enum logic {
		FUNC_SIN = 1'b0,
		FUNC_COS = 1'b1
	} func_t;

	localparam logic [8:0] DIV_SIN [MAX_TERMS] = '{
		9'd1, 9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272, 9'd342};
	localparam logic [8:0] DIV_COS [MAX_TERMS] = '{
		9'd1, 9'd2, 9'd12, 9'd30, 9'd56, 9'd90, 9'd132, 9'd182, 9'd240, 9'd306};

	// floor(2^64/d); the first entry is never used
	localparam logic [63:0] RECIP_SIN [MAX_TERMS] = '{
		64'(TWO_64 / 65'd1),   64'(TWO_64 / 65'd6),   64'(TWO_64 / 65'd20),
		64'(TWO_64 / 65'd42),  64'(TWO_64 / 65'd72),  64'(TWO_64 / 65'd110),
		64'(TWO_64 / 65'd156), 64'(TWO_64 / 65'd210), 64'(TWO_64 / 65'd272),
		64'(TWO_64 / 65'd342)};
	localparam logic [63:0] RECIP_COS [MAX_TERMS] = '{
		64'(TWO_64 / 65'd1),   64'(TWO_64 / 65'd2),   64'(TWO_64 / 65'd12),
		64'(TWO_64 / 65'd30),  64'(TWO_64 / 65'd56),  64'(TWO_64 / 65'd90),
		64'(TWO_64 / 65'd132), 64'(TWO_64 / 65'd182), 64'(TWO_64 / 65'd240),
		64'(TWO_64 / 65'd306)};

	// word handed from the front end to the series pipeline
	typedef struct packed {
		func_t       func;
		logic        flip;
		logic [62:0] x;
		logic [63:0] x2;
	} front_item_t;

	// word moving along the series pipeline
	typedef struct packed {
		func_t       func;
		logic        flip;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
	} term_bus_t;

endpackage

// ===== hdl/tsc_front.sv =====
// Front end: angle to fraction of a turn, quadrant fold, x and x^2 in Q2.62.
// Depends on tsc_pkg.
module tsc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_vld,
	input  tsc_pkg::func_t      in_func,
	input  logic [31:0]         in_angle,
	output logic                push,
	output tsc_pkg::front_item_t item
);
	import tsc_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	func_t func_s1, func_s2, func_s3, func_s4, func_s5;
	logic flip_s2, flip_s3, flip_s4, flip_s5;

	logic signed [64:0] p_lo;
	logic signed [39:0] p_hi;
	logic [63:0] p_lo_s1;
	logic [31:0] p_hi_s1;

	logic [31:0] turn, t1, t2;
	logic        flip;
	logic [30:0] turn_s2;

	logic [62:0] xp;
	logic [62:0] x_s3, x_s4, x_s5;

	logic [61:0] hh_s4;
	logic [62:0] hl_s4;
	logic [63:0] ll_s4;
	logic [127:0] full;
	logic [63:0] x2_s5;

	assign p_lo = $signed(in_angle) * $signed({1'b0, TURN_KL});
	assign p_hi = $signed(in_angle) * $signed({1'b0, TURN_KH});

	// fold into [0, quarter turn]; boundaries themselves are not folded
	always_comb begin
		turn = p_lo_s1[63:32] + p_hi_s1;
		flip = 1'b0;
		if (func_s1 == FUNC_SIN) begin
			t1 = turn;
			if (turn > HALF_TURN) begin
				t1   = turn - HALF_TURN;
				flip = 1'b1;
			end
			t2 = (t1 > QUARTER_TURN) ? (HALF_TURN - t1) : t1;
		end else begin
			t1 = (turn > HALF_TURN) ? (32'd0 - turn) : turn;
			t2 = t1;
			if (t1 > QUARTER_TURN) begin
				t2   = HALF_TURN - t1;
				flip = 1'b1;
			end
		end
	end

	assign xp   = turn_s2 * TWO_PI_L;
	assign full = {2'b0, hh_s4, 64'b0} + {32'b0, hl_s4, 33'b0} + {64'b0, ll_s4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s1 <= in_func;
			p_lo_s1 <= p_lo[63:0];
			p_hi_s1 <= p_hi[31:0];

			func_s2 <= func_s1;
			flip_s2 <= flip;
			turn_s2 <= t2[30:0];

			func_s3 <= func_s2;
			flip_s3 <= flip_s2;
			x_s3    <= xp + {turn_s2, 32'b0};

			func_s4 <= func_s3;
			flip_s4 <= flip_s3;
			x_s4    <= x_s3;
			hh_s4   <= x_s3[62:32] * x_s3[62:32];
			hl_s4   <= x_s3[62:32] * x_s3[31:0];
			ll_s4   <= x_s3[31:0] * x_s3[31:0];

			func_s5 <= func_s4;
			flip_s5 <= flip_s4;
			x_s5    <= x_s4;
			x2_s5   <= full[125:62];
		end
	end

	assign push      = en && vld_s5;
	assign item.func = func_s5;
	assign item.flip = flip_s5;
	assign item.x    = x_s5;
	assign item.x2   = x2_s5;

endmodule

// ===== hdl/tsc_fifo.sv =====
// Short queue between the front end and the series pipeline.
// Depends on tsc_pkg.
module tsc_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic                 pop,
	input  tsc_pkg::front_item_t din,
	output tsc_pkg::front_item_t dout,
	output logic                 full,
	output logic                 empty
);
	import tsc_pkg::*;

	front_item_t        mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q, rd_q;
	logic [FIFO_AW:0]   count_q;

	assign full  = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign empty = (count_q == '0);
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= din;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) full |-> !push)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) empty |-> !pop)
		else $error("pop from empty queue");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not advance");

endmodule

// ===== hdl/tsc_term.sv =====
// One series term: term*x^2 >> 62, divide by the term's constant, accumulate.
// Depends on tsc_pkg; five pipeline stages.
module tsc_term (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic [3:0]          k,
	input  logic [3:0]          n,
	input  logic                in_vld,
	input  tsc_pkg::term_bus_t  bus_i,
	output logic                out_vld,
	output tsc_pkg::term_bus_t  bus_o
);
	import tsc_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	term_bus_t bus_s1, bus_s2, bus_s3, bus_s4, bus_s5;

	logic [63:0] ll_s1, lh_s1, hl_s1, hh_s1;
	logic [127:0] full_a;
	logic [63:0] prod_s2;

	logic [63:0] recip;
	logic [63:0] ll_s3, lh_s3, hl_s3, hh_s3;
	logic [15:0] tlow_s3, tlow_s4;
	logic [127:0] full_b;
	logic [63:0] q_s4;

	logic [8:0]  d;
	logic [15:0] r;
	logic        c;
	logic [63:0] term_new, sum_new;
	term_bus_t   bus_nxt;

	assign full_a = {hh_s1, 64'b0} + {32'b0, lh_s1, 32'b0} + {32'b0, hl_s1, 32'b0}
		+ {64'b0, ll_s1};
	assign recip  = (bus_s2.func == FUNC_COS) ? RECIP_COS[k] : RECIP_SIN[k];
	assign full_b = {hh_s3, 64'b0} + {32'b0, lh_s3, 32'b0} + {32'b0, hl_s3, 32'b0}
		+ {64'b0, ll_s3};

	// estimate is exact or one short; the remainder decides
	always_comb begin
		d        = (bus_s4.func == FUNC_COS) ? DIV_COS[k] : DIV_SIN[k];
		r        = tlow_s4 - 16'(q_s4[15:0] * {7'b0, d});
		c        = (r >= {7'b0, d});
		term_new = q_s4 + {63'b0, c};
		// odd terms subtract: sum - q - c == sum + ~q + !c
		sum_new  = k[0] ? (bus_s4.sum + ~q_s4 + {63'b0, !c})
		                : (bus_s4.sum + q_s4 + {63'b0, c});
		// hold the sum once past the configured term count
		bus_nxt      = bus_s4;
		bus_nxt.term = term_new;
		if (k < n) bus_nxt.sum = sum_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bus_s1 <= bus_i;
			ll_s1  <= bus_i.term[31:0] * bus_i.x2[31:0];
			lh_s1  <= bus_i.term[31:0] * bus_i.x2[63:32];
			hl_s1  <= bus_i.term[63:32] * bus_i.x2[31:0];
			hh_s1  <= bus_i.term[63:32] * bus_i.x2[63:32];

			bus_s2  <= bus_s1;
			prod_s2 <= full_a[125:62];

			bus_s3  <= bus_s2;
			tlow_s3 <= prod_s2[15:0];
			ll_s3   <= prod_s2[31:0] * recip[31:0];
			lh_s3   <= prod_s2[31:0] * recip[63:32];
			hl_s3   <= prod_s2[63:32] * recip[31:0];
			hh_s3   <= prod_s2[63:32] * recip[63:32];

			bus_s4  <= bus_s3;
			tlow_s4 <= tlow_s3;
			q_s4    <= full_b[127:64];

			bus_s5 <= bus_nxt;
		end
	end

	assign out_vld = vld_s5;
	assign bus_o   = bus_s5;

	a_sum_held: assert property (@(posedge clk) disable iff (!arst_n)
		(en && vld_s4 && !(k < n)) |=> (bus_s5.sum == $past(bus_s4.sum)))
		else $error("unused term changed the sum");

endmodule

// ===== hdl/tsc_out.sv =====
// Output stage: magnitude, round to Q2.30, saturate to one, apply sign.
// Depends on tsc_pkg; its second stage is the result register.
module tsc_out (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  tsc_pkg::term_bus_t bus_i,
	output logic               out_vld,
	output logic [31:0]        value
);
	import tsc_pkg::*;

	logic        vld_s1, vld_s2;
	logic [63:0] mag_s1;
	logic        sgn_s1;
	logic [31:0] value_s2;
	logic [64:0] rnd;
	logic [31:0] sat;

	assign rnd = {1'b0, mag_s1} + {33'b0, HALF_TURN};
	assign sat = (rnd[64:32] > {1'b0, ONE_Q30}) ? ONE_Q30 : rnd[63:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1   <= bus_i.sum[63] ? (64'd0 - bus_i.sum) : bus_i.sum;
			sgn_s1   <= bus_i.sum[63] ^ bus_i.flip;
			value_s2 <= sgn_s1 ? (32'd0 - sat) : sat;
		end
	end

	assign out_vld = vld_s2;
	assign value   = value_s2;

endmodule

// ===== hdl/taylor_sine_cosine_core.sv =====
// Sine/cosine core: Taylor series after quadrant reduction, Q8.24 in, Q2.30 out.
// Depends on tsc_pkg, tsc_front, tsc_fifo, tsc_term and tsc_out.
//
// Input channel s_*: s_tdata carries the angle (signed Q8.24 radians), s_tuser
// selects sine (0) or cosine (1). Output channel m_*: m_tdata carries the
// signed Q2.30 result, saturated to plus or minus one. term_count_we with
// term_count_wdata sets the number of series terms (0 acts as 1, above 10 as
// 10); write it only while no word is in flight.
//
// One word is accepted per cycle while s_tready is high and one result leaves per
// cycle while m_tready is high. An accepted word passes the first front stage, which
// loads at the accepting edge, then 4 more front stages (fold, x, x^2 partial products,
// x^2 sum), the queue, 5 stages for each of the nine series terms (two split 64x64
// multiplies and a remainder correction), and 2 output stages. Reset clears all
// valid bits and the queue and sets the term count to 6.
// When m_tvalid is high and m_tready low the series pipeline holds; the front end
// keeps accepting until the four-entry queue fills, then drops s_tready.
module taylor_sine_cosine_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,          // [31:0] angle
	input  logic        s_tuser,          // [0] func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,          // [31:0] value
	input  logic        term_count_we,
	input  logic [3:0]  term_count_wdata
);
	import tsc_pkg::*;

	logic [3:0] term_count_q;
	logic [3:0] n;

	logic        en_f, en_b;
	logic        push, pop, full, empty;
	front_item_t fr_item, fifo_out;

	logic      vld [MAX_TERMS];
	term_bus_t bus [MAX_TERMS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) term_count_q <= TERMS_RESET;
		else if (term_count_we) term_count_q <= term_count_wdata;
	end

	always_comb begin
		priority if (term_count_q == 4'd0) n = 4'd1;
		else if (term_count_q > 4'(MAX_TERMS)) n = 4'(MAX_TERMS);
		else n = term_count_q;
	end

	assign en_f     = !full;
	assign s_tready = en_f;
	assign en_b     = !m_tvalid || m_tready;
	assign pop      = en_b && !empty;

	tsc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en_f),
		.in_vld   (s_tvalid),
		.in_func  (func_t'(s_tuser)),
		.in_angle (s_tdata),
		.push     (push),
		.item     (fr_item)
	);

	tsc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.din    (fr_item),
		.dout   (fifo_out),
		.full   (full),
		.empty  (empty)
	);

	// first term is x for sine, one for cosine
	always_comb begin
		vld[0]      = !empty;
		bus[0].func = fifo_out.func;
		bus[0].flip = fifo_out.flip;
		bus[0].x2   = fifo_out.x2;
		bus[0].term = (fifo_out.func == FUNC_COS) ? ONE_Q62 : {1'b0, fifo_out.x};
		bus[0].sum  = bus[0].term;
	end

	for (genvar g = 1; g < MAX_TERMS; g++) begin : g_term
		tsc_term u_term (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en_b),
			.k       (4'(g)),
			.n       (n),
			.in_vld  (vld[g-1]),
			.bus_i   (bus[g-1]),
			.out_vld (vld[g]),
			.bus_o   (bus[g])
		);
	end

	tsc_out u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en_b),
		.in_vld  (vld[MAX_TERMS-1]),
		.bus_i   (bus[MAX_TERMS-1]),
		.out_vld (m_tvalid),
		.value   (m_tdata)
	);

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result changed while stalled");
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata) <= $signed(ONE_Q30)
		&& $signed(m_tdata) >= -$signed(ONE_Q30)))
		else $error("result beyond plus or minus one");
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !full)
		else $error("ready while queue full");

endmodule

// ===== tb/tb_taylor_sine_cosine_core.sv =====
// Testbench for taylor_sine_cosine_core: drives angles and sine/cosine selects, predicts
// each result with a fixed-point series model and checks it in order.
// Depends on tsc_pkg and the RTL in hdl/.
module tb_taylor_sine_cosine_core;
	timeunit 1ns;
	timeprecision 1ps;
	import tsc_pkg::*;

	class sincos_scoreboard;
		logic [31:0] expected_values[$];
		int mismatches;
		logic [3:0] terms;

		function new();
			mismatches = 0;
			terms = TERMS_RESET;
		endfunction

		// floor(a*b / 2^62)
		function logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
			logic [127:0] p;
			p = {64'd0, a} * {64'd0, b};
			return p[125:62];
		endfunction

		function logic [31:0] predict_value(func_t f, logic [31:0] ang);
			logic [63:0] a64, prod, x, x2, term, sum, mag;
			logic [31:0] turn;
			logic flip, neg;
			int n;
			logic [63:0] d;
			flip = 1'b0;
			a64 = {{32{ang[31]}}, ang};
			prod = a64 * 64'h28BE60DB94;
			turn = prod[63:32];
			if (f == FUNC_SIN) begin
				if (turn > HALF_TURN) begin
					turn = turn - HALF_TURN;
					flip = 1'b1;
				end
				if (turn > QUARTER_TURN)
					turn = HALF_TURN - turn;
			end else begin
				if (turn > HALF_TURN)
					turn = 32'(64'h1_0000_0000 - {32'd0, turn});
				if (turn > QUARTER_TURN) begin
					turn = HALF_TURN - turn;
					flip = 1'b1;
				end
			end
			x = {32'd0, turn} * 64'h1921FB544;
			x2 = mul_q62(x, x);
			n = terms;
			if (n < 1) n = 1;
			if (n > MAX_TERMS) n = MAX_TERMS;
			term = (f == FUNC_COS) ? ONE_Q62 : x;
			sum = term;
			for (int k = 1; k < n; k++) begin
				d = (f == FUNC_COS) ? 64'(DIV_COS[k]) : 64'(DIV_SIN[k]);
				term = mul_q62(term, x2) / d;
				if (k % 2) sum = sum - term;
				else sum = sum + term;
			end
			neg = sum[63];
			mag = neg ? -sum : sum;
			mag = (mag + 64'h8000_0000) >> 32;
			if (mag > 64'(ONE_Q30)) mag = 64'(ONE_Q30);
			return (neg ^ flip) ? -mag[31:0] : mag[31:0];
		endfunction

		function void note_angle(func_t f, logic [31:0] ang);
			expected_values.push_back(predict_value(f, ang));
		endfunction

		function void check_value(logic [31:0] got);
			logic [31:0] want;
			if (expected_values.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word %h", got);
				return;
			end
			want = expected_values.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("value mismatch: expected %h got %h", want, got);
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic s_tvalid = 0, s_tready, s_tuser = 0;
	logic [31:0] s_tdata = '0;
	logic m_tvalid, m_tready = 0;
	logic [31:0] m_tdata;
	logic term_count_we = 0;
	logic [3:0] term_count_wdata = '0;
	bit sending_done = 0;
	sincos_scoreboard sb = new();

	taylor_sine_cosine_core dut (.*);

	always #5 clk = ~clk;

	initial begin
		#20ms;
		$display("CHECK FAILED");
		$finish;
	end

	// result side: random stall before each word, check each accepted word
	initial begin
		int w;
		forever begin
			w = $urandom_range(0, 3);
			if (w > 0) begin
				m_tready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_value(m_tdata);
		end
	end

	bit no_gaps = 0;

	task automatic send_angle(func_t f, logic [31:0] ang);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= f;
		s_tdata <= ang;
		do @(posedge clk); while (!s_tready);
		sb.note_angle(f, ang);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.expected_values.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic set_terms(logic [3:0] v);
		term_count_we <= 1'b1;
		term_count_wdata <= v;
		@(posedge clk);
		term_count_we <= 1'b0;
		sb.terms = v;
	endtask

	function automatic logic [31:0] rand_angle();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 32'h0D00_0000)) - 32'sh0680_0000);
			2: return {{8{1'b0}}, 24'($urandom())} ^ {32{$urandom_range(0, 1) == 1}};
			default: return 32'($urandom_range(0, 8)) * 32'h0192_1FB5 + $urandom_range(0, 3) - 1;
		endcase
	endfunction

	initial begin
		logic [3:0] settings[8] = '{4'd6, 4'd1, 4'd10, 4'd0, 4'd15, 4'd3, 4'd11, 4'd8};
		logic [31:0] corners[12] = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
			32'h0000_0001, 32'h0192_1FB5, 32'h0324_3F6A, 32'h0648_7ED5, 32'h0096_8000,
			32'hFCDB_C096, 32'h00C9_0FDB, 32'h0100_0000};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (corners[i]) begin
			send_angle(FUNC_SIN, corners[i]);
			send_angle(FUNC_COS, corners[i]);
		end
		drain();
		foreach (settings[p]) begin
			set_terms(settings[p]);
			no_gaps = (p == 2);
			for (int i = 0; i < 165; i++)
				send_angle(func_t'($urandom_range(0, 1)), rand_angle());
			drain();
		end
		if (sb.mismatches == 0 && sb.expected_values.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

// ===== taylor_sine_cosine_core.f =====
hdl/tsc_pkg.sv
hdl/tsc_front.sv
hdl/tsc_fifo.sv
hdl/tsc_term.sv
hdl/tsc_out.sv
hdl/taylor_sine_cosine_core.sv
tb/tb_taylor_sine_cosine_core.sv
